@@ sv/bste_pkg.sv @@
package bste_pkg;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_ADD    = 3'd1,
    OP_MEMBER = 3'd2,
    OP_UNION  = 3'd3,
    OP_INTER  = 3'd4
  } op_e;

  // one-hot sequencer states
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,  // search target set for element
    S_SWAIT = 9'b000000100,  // read latency of scan
    S_SRCR  = 9'b000001000,  // fetch next source word
    S_SRCW  = 9'b000010000,  // source word arrives
    S_INNR  = 9'b000100000,  // intersection: scan set_b for source word
    S_INNW  = 9'b001000000,
    S_WRITE = 9'b010000000,  // append to target
    S_DONE  = 9'b100000000
  } state_e;

endpackage

@@ sv/bste_ram.sv @@
module bste_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/bounded_set_table_engine_unit.sv @@
// Set table engine: NUM_SETS sets of up to SET_CAPACITY 32-bit words, held in one
// single-port-read RAM, NUM_SETS*SET_CAPACITY deep, with valid flags and counts in
// flops. One operation is in flight at a time; the next word is taken once ok_o is
// delivered. Add and member test scan the target set one element at a time, each
// element a RAM read and a compare. Union reads each source word and then scans the
// destination; intersection scans set_b for each set_a word and, on a match, the
// destination. The RAM read port, shared by all scans, sets the rate.
module bounded_set_table_engine_unit
  import bste_pkg::*;
#(
  parameter int unsigned NUM_SETS     = 27,
  parameter int unsigned SET_CAPACITY = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  operation_i,
  input  logic [4:0]  set_a_i,
  input  logic [4:0]  set_b_i,
  input  logic [4:0]  set_dest_i,
  input  logic signed [31:0] element_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        ok_o
);

  localparam int unsigned Depth = NUM_SETS * SET_CAPACITY;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  state_e st_q, st_d;
  logic [NUM_SETS-1:0] vld_q, vld_d;
  logic [7:0] cnt_q [NUM_SETS];
  logic [7:0] cnt_d [NUM_SETS];

  logic [2:0]  op_q, op_d;
  logic [SW-1:0] a_q, a_d, b_q, b_d, t_q, t_d;   // t = target of add/scan
  logic [31:0] elem_q, elem_d;                  // word under test
  logic [7:0]  i_q, i_d;                        // scan index
  logic [7:0]  si_q, si_d;                      // source index
  logic        phase_q, phase_d;                // union: 0 set_a, 1 set_b
  logic        ok_q, ok_d, ov_q, ov_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  bste_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(elem_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  function automatic logic [AW-1:0] addr_of(logic [SW-1:0] s, logic [7:0] i);
    logic [AW+8:0] full;
    full = AW'(s) * (AW+9)'(SET_CAPACITY) + (AW+9)'(i);
    return full[AW-1:0];
  endfunction

  logic in_acc, in_range_a, in_range_b, in_range_d;
  assign in_acc     = valid_i && !stall_o;
  assign stall_o    = (st_q != S_IDLE) || ov_q;
  assign valid_o    = ov_q;
  assign ok_o       = ok_q;
  assign in_range_a = 32'(set_a_i) < NUM_SETS;
  assign in_range_b = 32'(set_b_i) < NUM_SETS;
  assign in_range_d = 32'(set_dest_i) < NUM_SETS;

  // source set for combine phase
  logic [SW-1:0] src;
  assign src = (op_q == OP_UNION && phase_q) ? b_q : a_q;
  logic [SW-1:0] dst_q, dst_d;

  always_comb begin
    st_d = st_q; vld_d = vld_q; cnt_d = cnt_q;
    op_d = op_q; a_d = a_q; b_d = b_q; t_d = t_q; dst_d = dst_q;
    elem_d = elem_q; i_d = i_q; si_d = si_q; phase_d = phase_q;
    ok_d = ok_q; ov_d = ov_q;
    ram_we = 1'b0; ram_waddr = addr_of(t_q, cnt_q[t_q]);
    ram_raddr = addr_of(t_q, i_q);
    if (ov_q && !stall_i) ov_d = 1'b0;
    case (st_q)
      S_IDLE: if (in_acc) begin
        op_d = operation_i; a_d = SW'(set_a_i); b_d = SW'(set_b_i);
        dst_d = SW'(set_dest_i); t_d = SW'(set_a_i);
        elem_d = element_i; i_d = '0; si_d = '0; phase_d = 1'b0;
        ok_d = 1'b0; st_d = S_DONE;
        case (operation_i)
          OP_CREATE: if (in_range_a && !vld_q[SW'(set_a_i)]) begin
            vld_d[SW'(set_a_i)] = 1'b1; ok_d = 1'b1;
          end
          OP_ADD, OP_MEMBER: if (in_range_a && vld_q[SW'(set_a_i)]) st_d = S_SCAN;
          OP_UNION, OP_INTER:
            if (in_range_a && in_range_b && in_range_d &&
                vld_q[SW'(set_a_i)] && vld_q[SW'(set_b_i)]) begin
              vld_d[SW'(set_dest_i)] = 1'b1; ok_d = 1'b1;
              t_d = SW'(set_dest_i); st_d = S_SRCR;
            end
          default: ;
        endcase
      end
      S_SCAN: begin
        // target set t_q, looking for elem_q
        if (i_q >= cnt_q[t_q]) begin
          if (op_q == OP_MEMBER) st_d = S_DONE;
          else if (cnt_q[t_q] >= 8'(SET_CAPACITY)) st_d = (op_q == OP_ADD) ? S_DONE : S_SRCR;
          else st_d = S_WRITE;
        end else st_d = S_SWAIT;
      end
      S_SWAIT: begin
        if (ram_rdata == elem_q) begin
          if (op_q == OP_MEMBER) ok_d = 1'b1;
          st_d = (op_q == OP_ADD || op_q == OP_MEMBER) ? S_DONE : S_SRCR;
        end else begin
          i_d = i_q + 8'd1; st_d = S_SCAN;
        end
      end
      S_WRITE: begin
        ram_we = 1'b1;
        cnt_d[t_q] = cnt_q[t_q] + 8'd1;
        if (op_q == OP_ADD) begin
          ok_d = 1'b1; st_d = S_DONE;
        end else st_d = S_SRCR;
      end
      S_SRCR: begin
        ram_raddr = addr_of(src, si_q);
        t_d = dst_q; i_d = '0;
        if (si_q >= cnt_q[src]) begin
          if (op_q == OP_UNION && !phase_q) begin
            phase_d = 1'b1; si_d = '0;
          end else st_d = S_DONE;
        end else st_d = S_SRCW;
      end
      S_SRCW: begin
        elem_d = ram_rdata; si_d = si_q + 8'd1;
        if (op_q == OP_UNION) st_d = S_SCAN;
        else st_d = S_INNR;
      end
      S_INNR: begin
        ram_raddr = addr_of(b_q, i_q);
        if (i_q >= cnt_q[b_q]) st_d = S_SRCR;
        else st_d = S_INNW;
      end
      S_INNW: begin
        if (ram_rdata == elem_q) begin
          // found in set_b; the set_b scan ends here and the destination scan
          // follows, so a later match of the same word is never looked for
          i_d = '0; st_d = S_SCAN;
        end else begin
          i_d = i_q + 8'd1; st_d = S_INNR;
        end
      end
      S_DONE: begin
        ov_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; vld_q <= '0; ov_q <= 1'b0;
      for (int k = 0; k < NUM_SETS; k++) cnt_q[k] <= '0;
    end else begin
      st_q <= st_d; vld_q <= vld_d; ov_q <= ov_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; a_q <= a_d; b_q <= b_d; t_q <= t_d; dst_q <= dst_d;
    elem_q <= elem_d; i_q <= i_d; si_q <= si_d; phase_q <= phase_d; ok_q <= ok_d;
  end

endmodule

@@ sv/bste_checker.sv @@
module bste_assert (
  input logic clk_i,
  input logic rst_ni,
  input logic valid_i,
  input logic stall_o,
  input logic valid_o,
  input logic stall_i,
  input logic ok_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(ok_o)) else $error("result dropped");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o) else $error("accept with result pending");
  a_one_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> !valid_o) else $error("result too early");

endmodule

bind bounded_set_table_engine_unit bste_assert u_chk (.*);
